// File: sv/dmc_pkg.sv
// dmc_pkg: shared types, widths, register indexes and helpers for the
// direct-mapped cache hit counter. No dependencies.
`default_nettype none

package dmc_pkg;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int OFFSET_W    = 4;
    localparam int INDEX_W_W   = 5;
    localparam int SHIFT_W     = 6;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_WIDTH  = 4'd1;

    localparam logic [OFFSET_W-1:0]  OFFSET_RESET = 4'd2;
    localparam logic [INDEX_W_W-1:0] INDEX_RESET  = 5'd14;
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX   = 4'd8;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } dmc_entry_t;

    localparam int ENTRY_W = $bits(dmc_entry_t);

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: sv/dmc_ram.sv
// dmc_ram: generic single-clock ram, one write port and one registered read port
// (read returns the old word on a same-address write). No dependencies.
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/dmc_addr_split.sv
// dmc_addr_split: clamps the configured widths and splits a byte address
// into line index and tag. Depends on dmc_pkg.
`default_nettype none

module dmc_addr_split
    import dmc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 17
) (
    input  wire logic [ADDR_W-1:0]         address,
    input  wire logic [OFFSET_W-1:0]       offset_width,
    input  wire logic [INDEX_W_W-1:0]      index_width,
    output logic      [MAX_INDEX_BITS-1:0] line,
    output logic      [TAG_W-1:0]          tag
);

    localparam logic [INDEX_W_W-1:0] INDEX_MAX = INDEX_W_W'(MAX_INDEX_BITS);

    logic [OFFSET_W-1:0]       off_eff;
    logic [INDEX_W_W-1:0]      iw_eff;
    logic [ADDR_W-1:0]         shifted;
    logic [MAX_INDEX_BITS-1:0] mask;
    logic [SHIFT_W-1:0]        shift_sum;

    always_comb
    begin
        off_eff   = (offset_width > OFFSET_MAX) ? OFFSET_MAX : offset_width;
        iw_eff    = (index_width > INDEX_MAX) ? INDEX_MAX : index_width;
        shifted   = address >> off_eff;
        mask      = ~({MAX_INDEX_BITS{1'b1}} << iw_eff);
        line      = shifted[MAX_INDEX_BITS-1:0] & mask;
        shift_sum = SHIFT_W'(off_eff) + SHIFT_W'(iw_eff);
        tag       = address >> shift_sum;
    end

endmodule

`default_nettype wire

// File: sv/direct_mapped_cache_hit_counter_top.sv
// direct_mapped_cache_hit_counter_top: tag store lookup with hit/miss counters.
// Depends on dmc_pkg, dmc_ram, dmc_addr_split.
//
//   channel   signals                          direction  handshake
//   in        address                          in         in_valid / in_stall
//   out       hit, hit_count, miss_count       out        out_valid / out_stall
//   cfg       cfg_index, cfg_data              in         cfg_valid / cfg_ready
//
// one address transaction per cycle while in_stall is low; the tag ram is read at
// acceptance, and the lookup stage compares, writes back on a miss and registers the result
// after reset a clearing pass writes every line of the tag ram with in_stall high;
// cfg_ready is always high
// a stalled output holds the lookup stage, which in turn stalls the input
`default_nettype none

module direct_mapped_cache_hit_counter_top
    import dmc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 17
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [ADDR_W-1:0]      address,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        hit,
    output logic      [COUNT_W-1:0]     hit_count,
    output logic      [COUNT_W-1:0]     miss_count,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LINE_W     = MAX_INDEX_BITS;
    localparam int LINE_COUNT = 1 << MAX_INDEX_BITS;

    logic [OFFSET_W-1:0]  offset_width_reg;
    logic [INDEX_W_W-1:0] index_width_reg;

    logic              clear_busy_reg;
    logic [LINE_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    logic [LINE_W-1:0] s1_line_reg;
    logic [TAG_W-1:0]  s1_tag_reg;

    // write issued in the same cycle as the pending read
    logic              byp_valid_reg;
    logic [LINE_W-1:0] byp_line_reg;
    logic [TAG_W-1:0]  byp_tag_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic [COUNT_W-1:0] miss_count_reg;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_hit;
    logic [LINE_W-1:0] split_line;
    logic [TAG_W-1:0]  split_tag;
    logic [ENTRY_W-1:0] rd_word;
    dmc_entry_t        stored;
    logic              ram_wr_en;
    logic [LINE_W-1:0] ram_wr_addr;
    dmc_entry_t        ram_wr_data;

    dmc_addr_split #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS)
    ) u_split (
        .address      (address),
        .offset_width (offset_width_reg),
        .index_width  (index_width_reg),
        .line         (split_line),
        .tag          (split_tag)
    );

    dmc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LINE_COUNT)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (split_line),
        .rd_data (rd_word)
    );

    always_comb
    begin
        s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall  = clear_busy_reg || (s1_valid_reg && !s1_adv);
        in_accept = in_valid && !in_stall;

        stored = dmc_entry_t'(rd_word);
        if (byp_valid_reg && (byp_line_reg == s1_line_reg))
        begin
            stored.valid = 1'b1;
            stored.tag   = byp_tag_reg;
        end
        s1_hit = stored.valid && (stored.tag == s1_tag_reg);

        if (clear_busy_reg)
        begin
            ram_wr_en         = 1'b1;
            ram_wr_addr       = clr_addr_reg;
            ram_wr_data.valid = 1'b0;
            ram_wr_data.tag   = '0;
        end
        else
        begin
            ram_wr_en         = s1_adv && !s1_hit;
            ram_wr_addr       = s1_line_reg;
            ram_wr_data.valid = 1'b1;
            ram_wr_data.tag   = s1_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_width_reg <= OFFSET_RESET;
            index_width_reg  <= INDEX_RESET;
            clear_busy_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            byp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            hit_count_reg    <= '0;
            miss_count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_OFFSET_WIDTH: offset_width_reg <= cfg_data[OFFSET_W-1:0];
                    CFG_INDEX_WIDTH:  index_width_reg  <= cfg_data[INDEX_W_W-1:0];
                    default:          ;
                endcase
            end

            if (clear_busy_reg)
            begin
                if (clr_addr_reg == {LINE_W{1'b1}})
                begin
                    clear_busy_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + LINE_W'(1);
            end

            if (in_accept)
            begin
                s1_valid_reg  <= 1'b1;
                byp_valid_reg <= s1_adv && !s1_hit;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                if (s1_hit)
                begin
                    hit_count_reg <= sat_inc(hit_count_reg);
                end
                else
                begin
                    miss_count_reg <= sat_inc(miss_count_reg);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_line_reg  <= split_line;
            s1_tag_reg   <= split_tag;
            byp_line_reg <= s1_line_reg;
            byp_tag_reg  <= s1_tag_reg;
        end
        if (s1_adv)
        begin
            hit_reg <= s1_hit;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign hit_count  = hit_count_reg;
    assign miss_count = miss_count_reg;

endmodule

`default_nettype wire

// File: sv/dmc_checker.sv
// dmc_checker: port-level assertions for the cache hit counter, bound to the top.
// Depends on dmc_pkg and direct_mapped_cache_hit_counter_top.
`default_nettype none

module dmc_checker
    import dmc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic                   hit,
    input wire logic [COUNT_W-1:0]     hit_count,
    input wire logic [COUNT_W-1:0]     miss_count
);

    // clearing pass keeps the input stalled right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) == 1'b0 |-> in_stall)
        else $error("input not stalled during tag clearing pass");

    // back-to-back results: a hit adds one to the hit count only
    a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && !out_stall) && out_valid && hit |->
            miss_count == $past(miss_count) &&
            (hit_count == $past(hit_count) + COUNT_W'(1) || hit_count == {COUNT_W{1'b1}}))
        else $error("hit count step wrong");

    // back-to-back results: a miss adds one to the miss count only
    a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && !out_stall) && out_valid && !hit |->
            hit_count == $past(hit_count) &&
            (miss_count == $past(miss_count) + COUNT_W'(1) || miss_count == {COUNT_W{1'b1}}))
        else $error("miss count step wrong");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_count) &&
            $stable(miss_count))
        else $error("stalled result changed");

endmodule

bind direct_mapped_cache_hit_counter_top dmc_checker u_dmc_checker (.*);

`default_nettype wire

// File: verif/cache_lookup_checker.sv
// cache_lookup_checker: watches the address, result and register channels of the
// direct-mapped cache hit counter, predicts every lookup and compares the results.
// Depends on dmc_pkg.
`default_nettype none

module cache_lookup_checker
    import dmc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 17
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [ADDR_W-1:0]      address,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic                   hit,
    input  wire logic [COUNT_W-1:0]     hit_count,
    input  wire logic [COUNT_W-1:0]     miss_count,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = 1 << MAX_INDEX_BITS;
    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } lookup_result_t;

    bit                   line_valid [LINES];
    logic [TAG_W-1:0]     line_tag [LINES];
    logic [COUNT_W-1:0]   hits_total;
    logic [COUNT_W-1:0]   misses_total;
    logic [OFFSET_W-1:0]  offset_cfg;
    logic [INDEX_W_W-1:0] index_cfg;
    lookup_result_t       pending_lookups [$];
    int                   error_total = 0;

    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] a);
        int unsigned    off_eff;
        int unsigned    iw_eff;
        int unsigned    line;
        logic [TAG_W-1:0] tag;
        lookup_result_t r;
        off_eff = 32'((offset_cfg > OFFSET_MAX) ? OFFSET_MAX : offset_cfg);
        iw_eff  = (index_cfg > MAX_INDEX_BITS) ? 32'(MAX_INDEX_BITS) : 32'(index_cfg);
        line = (a >> off_eff) & ((32'd1 << iw_eff) - 32'd1);
        tag  = a >> (off_eff + iw_eff);
        r.hit = line_valid[line] && (line_tag[line] == tag);
        if (r.hit)
        begin
            if (hits_total != '1)
                hits_total = hits_total + COUNT_W'(1);
        end
        else
        begin
            if (misses_total != '1)
                misses_total = misses_total + COUNT_W'(1);
            // a miss fills the line, tags from older widths stay as they are
            line_valid[line] = 1'b1;
            line_tag[line]   = tag;
        end
        r.hit_count  = hits_total;
        r.miss_count = misses_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        if (error_total < PRINT_CAP)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
                line_valid[i] = 1'b0;
            pending_lookups.delete();
            offset_cfg   = OFFSET_RESET;
            index_cfg    = INDEX_RESET;
            hits_total   = '0;
            misses_total = '0;
            outstanding <= 0;
            mismatches  <= error_total;
        end
        else
        begin
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                if (cfg_index == CFG_OFFSET_WIDTH)
                    offset_cfg = cfg_data[OFFSET_W-1:0];
                else if (cfg_index == CFG_INDEX_WIDTH)
                    index_cfg = cfg_data;
            end
            if (in_valid && in_stall === 1'b0)
                pending_lookups.push_back(predict_lookup(address));
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_lookups.size() == 0)
                    report_mismatch("result with no lookup waiting, hit_count", hit_count, '0);
                else
                begin
                    want = pending_lookups.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", COUNT_W'(hit), COUNT_W'(want.hit));
                    if (hit_count !== want.hit_count)
                        report_mismatch("hit_count", hit_count, want.hit_count);
                    if (miss_count !== want.miss_count)
                        report_mismatch("miss_count", miss_count, want.miss_count);
                end
            end
            outstanding <= pending_lookups.size();
            mismatches  <= error_total;
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench: drives address and register transactions into the direct-mapped cache
// hit counter and gives the verdict. Depends on dmc_pkg, cache_lookup_checker and
// direct_mapped_cache_hit_counter_top.
`default_nettype none

module testbench
    import dmc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_INDEX_BITS = 17;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_WIDTH + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      address = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [COUNT_W-1:0]     hit_count;
    logic [COUNT_W-1:0]     miss_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     mismatches;
    int                     outstanding;

    int unsigned            send_idle_pct = 0;
    int unsigned            stall_pct = 0;
    int unsigned            cycle_count = 0;
    logic [ADDR_W-1:0]      address_pool [$];

    direct_mapped_cache_hit_counter_top #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_count(hit_count), .miss_count(miss_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cache_lookup_checker #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS)
    ) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .address(address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_count(hit_count), .miss_count(miss_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // the clearing pass after reset counts against the cycle limit too
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("direct_mapped_cache_hit_counter_top test failed");
            $finish;
        end
    end

    // mostly reuse of a small working set so that hits and conflicts are common
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int unsigned       roll;
        roll = $urandom_range(99);
        if (roll < 15 || address_pool.size() == 0)
            a = $urandom();
        else
        begin
            a = address_pool[$urandom_range(address_pool.size() - 1)];
            if (roll >= 85)
                a = a + ($urandom_range(15) << $urandom_range(24));
            else if (roll >= 65)
                a = a ^ ADDR_W'($urandom_range(255));
        end
        address_pool.push_back(a);
        if (address_pool.size() > 12)
            void'(address_pool.pop_front());
        return a;
    endfunction

    // valid is left high after the transaction so back-to-back sends need no re-raise
    task automatic send_address(input logic [ADDR_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    task automatic reconfigure(input logic [OFFSET_W-1:0] off, input logic [INDEX_W_W-1:0] iw,
                               input logic [CFG_INDEX_W-1:0] spare);
        wait_idle();
        repeat (4) @(posedge clk);
        // upper data bit is don't-care for the offset register
        write_register(CFG_OFFSET_WIDTH, {1'($urandom_range(1)), off});
        write_register(CFG_INDEX_WIDTH, iw);
        write_register(spare, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [OFFSET_W-1:0]  off;
        logic [INDEX_W_W-1:0] iw;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);

        // reset widths: offset 2, index 14
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'h0000_0003);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0001_0000);
        send_address(32'h0000_0000);

        // no offset and no index: whole address is the tag, one line
        reconfigure(4'd0, 5'd0, CFG_SPARE_LAST);
        send_address(32'h1234_5678);
        send_address(32'h1234_5678);
        send_address(32'h1234_5679);
        send_address(32'h1234_5678);

        // both widths beyond their range, clamped
        reconfigure(4'd15, 5'd31, CFG_SPARE_FIRST);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_00FF);
        send_address(32'h8000_0000);

        reconfigure(OFFSET_MAX, 5'(MAX_INDEX_BITS), CFG_SPARE_LAST);
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        send_address(32'hAAAA_AAAA);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            case (phase)
                0: begin off = 4'd0;  iw = 5'd0;  end
                1: begin off = 4'd8;  iw = 5'd17; end
                2: begin off = 4'd15; iw = 5'd31; end
                3: begin off = 4'd2;  iw = 5'd14; end
                4: begin off = 4'd1;  iw = 5'd3;  end
                5: begin off = 4'd0;  iw = 5'd17; end
                6: begin off = 4'd8;  iw = 5'd0;  end
                default:
                begin
                    off = OFFSET_W'($urandom_range(15));
                    iw  = INDEX_W_W'($urandom_range(31));
                end
            endcase
            reconfigure(off, iw, CFG_INDEX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)));
            address_pool.delete();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_address(pick_address());
                // sender holds off mid-phase until the pipeline is empty
                if (n == PHASE_ITEMS / 2 && phase % 2 == 1)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("direct_mapped_cache_hit_counter_top test passed");
        else
            $display("direct_mapped_cache_hit_counter_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/dmc_pkg.sv
sv/dmc_ram.sv
sv/dmc_addr_split.sv
sv/direct_mapped_cache_hit_counter_top.sv
sv/dmc_checker.sv
verif/cache_lookup_checker.sv
verif/testbench.sv
